FILE: rtl/fwsc_pkg.sv
package fwsc_pkg;

    localparam int MAX_CHARS_DEF = 64;
    localparam int CHAR_BITS_DEF = 32;

    localparam int LEN_BITS  = 7;
    localparam int OP_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int OUT_BITS  = 8;

    // ASCII codes that strip treats as trailing filler
    localparam int CODE_SPACE = 32;
    localparam int CODE_TAB   = 9;
    localparam int CODE_CR    = 13;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEN_A = 2'd0,
        CFG_LEN_B = 2'd1,
        CFG_STRIP = 2'd2,
        CFG_OP    = 2'd3
    } cfg_idx_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_EQ = 3'd0,
        OP_NE = 3'd1,
        OP_LT = 3'd2,
        OP_LE = 3'd3,
        OP_GT = 3'd4,
        OP_GE = 3'd5
    } cmp_op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_STRIP_RD,
        ST_STRIP_CHK,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_DONE
    } state_t;

    localparam logic [1:0] ORDER_LT = 2'b11;
    localparam logic [1:0] ORDER_EQ = 2'b00;
    localparam logic [1:0] ORDER_GT = 2'b01;

endpackage

FILE: rtl/fwsc_store.sv
module fwsc_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data_a,
    input  logic [WIDTH-1:0] wr_data_b,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_a [DEPTH];
    logic [WIDTH-1:0] mem_b [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data_a;
            mem_b[wr_addr] <= wr_data_b;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem_a[rd_addr_a];
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

FILE: rtl/fixed_width_string_compare.sv
// Character pairs load at one transaction per cycle into two string memories while the
// block is in the load state. The pair marked last starts the walk: a setup step; with
// strip on, a read and a check per strip step (one step per character dropped from the
// longer tail, one more to stop); a read and a check per compared position through the
// first difference, plus a read when none differs; then the result is posted.
// Reset clears control state and configuration (len_a = len_b = 1, strip off, op eq).
module fixed_width_string_compare #(
    parameter int MAX_CHARS = fwsc_pkg::MAX_CHARS_DEF,
    parameter int CHAR_BITS = fwsc_pkg::CHAR_BITS_DEF,
    parameter int DW        = ((2 * CHAR_BITS + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [DW-1:0]                    s_tdata,   // char_a, char_b
    input  logic                             s_tlast,   // last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fwsc_pkg::OUT_BITS-1:0]    m_tdata,   // holds, order[1:0]
    input  logic                             cfg_we,
    input  logic [fwsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [fwsc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import fwsc_pkg::*;

    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int LW = (CW > LEN_BITS) ? CW : LEN_BITS;

    state_t                state_reg, state_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         na_reg, na_next;
    logic [CW-1:0]         nb_reg, nb_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  done_a_reg, done_a_next;
    logic                  done_b_reg, done_b_next;
    logic                  lt_reg, lt_next;
    logic                  gt_reg, gt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  holds_reg, holds_next;
    logic [1:0]            order_reg, order_next;

    logic [LEN_BITS-1:0]   len_a_reg, len_b_reg;
    logic                  strip_reg;
    logic [OP_BITS-1:0]    op_reg;

    logic                  in_accept;
    logic                  wr_en;
    logic [AW-1:0]         rd_addr_a, rd_addr_b;
    logic [CHAR_BITS-1:0]  rd_data_a, rd_data_b;
    logic [CHAR_BITS-1:0]  ca, cb;
    logic                  strip_a_char, strip_b_char;
    logic [CW-1:0]         top;
    logic [LW-1:0]         lim_a, lim_b;
    logic                  out_load;
    logic                  res_lt, res_gt;

    assign s_tready  = (state_reg == ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign wr_en     = in_accept && (pos_reg < CW'(MAX_CHARS));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_BITS - 3){1'b0}}, order_reg, holds_reg};

    fwsc_store #(
        .DEPTH (MAX_CHARS),
        .WIDTH (CHAR_BITS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (AW'(pos_reg)),
        .wr_data_a (s_tdata[CHAR_BITS-1:0]),
        .wr_data_b (s_tdata[2*CHAR_BITS-1:CHAR_BITS]),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= LEN_BITS'(1);
            len_b_reg <= LEN_BITS'(1);
            strip_reg <= 1'b0;
            op_reg    <= OP_EQ;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LEN_A: len_a_reg <= cfg_data[LEN_BITS-1:0];
                CFG_LEN_B: len_b_reg <= cfg_data[LEN_BITS-1:0];
                CFG_STRIP: strip_reg <= cfg_data[0];
                CFG_OP:    op_reg    <= cfg_data[OP_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // effective sizes: saturate at the memory depth and at the loaded count
    always_comb
    begin
        lim_a = (LW'(len_a_reg) > LW'(MAX_CHARS)) ? LW'(MAX_CHARS) : LW'(len_a_reg);
        if (lim_a > LW'(pos_reg))
            lim_a = LW'(pos_reg);
        lim_b = (LW'(len_b_reg) > LW'(MAX_CHARS)) ? LW'(MAX_CHARS) : LW'(len_b_reg);
        if (lim_b > LW'(pos_reg))
            lim_b = LW'(pos_reg);
    end

    assign strip_a_char = (rd_data_a == '0) || (rd_data_a == CHAR_BITS'(CODE_SPACE)) ||
                          ((rd_data_a >= CHAR_BITS'(CODE_TAB)) &&
                           (rd_data_a <= CHAR_BITS'(CODE_CR)));
    assign strip_b_char = (rd_data_b == '0) || (rd_data_b == CHAR_BITS'(CODE_SPACE)) ||
                          ((rd_data_b >= CHAR_BITS'(CODE_TAB)) &&
                           (rd_data_b <= CHAR_BITS'(CODE_CR)));

    assign top = (na_reg > nb_reg) ? na_reg : nb_reg;
    assign ca  = (idx_reg < na_reg) ? rd_data_a : '0;
    assign cb  = (idx_reg < nb_reg) ? rd_data_b : '0;

    always_comb
    begin
        if (state_reg == ST_STRIP_RD)
        begin
            rd_addr_a = AW'(na_reg - 1'b1);
            rd_addr_b = AW'(nb_reg - 1'b1);
        end
        else
        begin
            rd_addr_a = AW'(idx_reg);
            rd_addr_b = AW'(idx_reg);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        idx_next    = idx_reg;
        done_a_next = done_a_reg;
        done_b_next = done_b_reg;
        lt_next     = lt_reg;
        gt_next     = gt_reg;
        out_load    = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (pos_reg < CW'(MAX_CHARS))
                        pos_next = pos_reg + 1'b1;
                    if (s_tlast)
                        state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                na_next     = CW'(lim_a);
                nb_next     = CW'(lim_b);
                done_a_next = 1'b0;
                done_b_next = 1'b0;
                idx_next    = '0;
                state_next  = strip_reg ? ST_STRIP_RD : ST_CMP_RD;
            end
            ST_STRIP_RD:
            begin
                state_next = ST_STRIP_CHK;
            end
            ST_STRIP_CHK:
            begin
                if (!done_a_reg)
                begin
                    if ((na_reg == '0) || !strip_a_char)
                        done_a_next = 1'b1;
                    else
                        na_next = na_reg - 1'b1;
                end
                if (!done_b_reg)
                begin
                    if ((nb_reg == '0) || !strip_b_char)
                        done_b_next = 1'b1;
                    else
                        nb_next = nb_reg - 1'b1;
                end
                state_next = (done_a_next && done_b_next) ? ST_CMP_RD : ST_STRIP_RD;
            end
            ST_CMP_RD:
            begin
                if (idx_reg == top)
                begin
                    lt_next    = 1'b0;
                    gt_next    = 1'b0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK:
            begin
                if (ca != cb)
                begin
                    lt_next    = (ca < cb);
                    gt_next    = (ca > cb);
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CMP_RD;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    pos_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign res_lt = lt_reg;
    assign res_gt = gt_reg;

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        holds_next   = holds_reg;
        order_next   = order_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            order_next   = res_lt ? ORDER_LT : (res_gt ? ORDER_GT : ORDER_EQ);
            case (cmp_op_t'(op_reg))
                OP_EQ:   holds_next = !res_lt && !res_gt;
                OP_NE:   holds_next = res_lt || res_gt;
                OP_LT:   holds_next = res_lt;
                OP_LE:   holds_next = !res_gt;
                OP_GT:   holds_next = res_gt;
                OP_GE:   holds_next = !res_lt;
                default: holds_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            pos_reg     <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
            idx_reg     <= '0;
            done_a_reg  <= 1'b0;
            done_b_reg  <= 1'b0;
            lt_reg      <= 1'b0;
            gt_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            na_reg      <= na_next;
            nb_reg      <= nb_next;
            idx_reg     <= idx_next;
            done_a_reg  <= done_a_next;
            done_b_reg  <= done_b_next;
            lt_reg      <= lt_next;
            gt_reg      <= gt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        holds_reg <= holds_next;
        order_reg <= order_next;
    end

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result posted outside the done state");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (order_reg == ORDER_LT || order_reg == ORDER_EQ ||
                         order_reg == ORDER_GT))
        else $error("invalid order code");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CW'(MAX_CHARS))
        else $error("load position past the memory depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_CHK) |-> (idx_reg < top))
        else $error("compare index past both strings");

    a_no_lt_gt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !(lt_reg && gt_reg))
        else $error("both less and greater flagged");

endmodule
